FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define SST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: sv/sst_pkg.sv
package sst_pkg;

   // table size and slot index width
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // command codes
   typedef enum logic [2:0] {
      ACT_OPEN    = 3'd0,
      ACT_CLOSE   = 3'd1,
      ACT_BIND    = 3'd2,
      ACT_CONNECT = 3'd3,
      ACT_LISTEN  = 3'd4,
      ACT_MARK    = 3'd5,
      ACT_GET     = 3'd6
   } action_type;

   // connection phases
   typedef enum logic [2:0] {
      PH_CREATED    = 3'd0,
      PH_BOUND      = 3'd1,
      PH_CONNECTING = 3'd2,
      PH_LISTENING  = 3'd3,
      PH_CONNECTED  = 3'd4
   } phase_type;

   // socket kinds
   localparam logic KIND_TCP = 1'b0;

   // request beat, last field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] port;
      logic [31:0] address;
      logic [1:0]  sock_type;
      logic [7:0]  handle;
      logic [2:0]  action;
   } req_item_type;

   // response beat, last field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] remote_port_out;
      logic [31:0] remote_ip;
      logic [15:0] local_port_out;
      logic [31:0] local_ip;
      logic [2:0]  entry_phase;
      logic        entry_kind;
      logic [7:0]  open_count;
      logic [7:0]  new_handle;
      logic        ok;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic lookup;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

FILE: sv/socket_slot_table.sv
// channel   direction  beat fields (low bit first)
// req_      in         action, handle, sock_type, address, port (64 bits)
// rsp_      out        ok, new_handle, open_count, entry_kind, entry_phase,
//                      local_ip, local_port_out, remote_ip, remote_port_out (120 bits)
//
// each command goes through accept, slot read and free-slot search, then
// table update with the result loaded into the output register.
// the registered lookup step lies between capture and update.
// a new command is taken while the previous result still waits on rsp_.
// a stalled rsp_ holds the finished command in its update step until the output frees.
// synchronous reset empties the table and clears the count.
module socket_slot_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // action, handle, sock_type, address, port
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata    // ok, new_handle, open_count, entry_kind, entry_phase,
                                     // local_ip, local_port_out, remote_ip, remote_port_out
);

   sst_pkg::cmd_type      cmd;
   sst_pkg::status_type   status;
   sst_pkg::req_item_type req_item;
   sst_pkg::rsp_item_type rsp_item;

   assign req_item  = sst_pkg::req_item_type'(req_tdata);
   assign rsp_tdata = 120'(rsp_item);

   // sequencer
   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // slot table and result register
   sst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: sv/sst_ctrl.sv
`include "assert_macros.svh"

module sst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sst_pkg::status_type status,
   output sst_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_EXEC   = 2'd2
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // commands follow the state
   always_comb begin
      cmd.load   = req_tvalid && ready_ff;
      cmd.lookup = (state_ff == ST_LOOKUP);
      cmd.exec   = (state_ff == ST_EXEC) && !status.out_busy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_EXEC;
         ST_EXEC: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

   `SST_ASSERT(a_accept_then_lookup, cmd.load |=> (state_ff == ST_LOOKUP), "accept did not start lookup")
   `SST_ASSERT(a_ready_only_idle, ready_ff |-> (state_ff == ST_IDLE), "ready outside idle")

endmodule

FILE: sv/sst_datapath.sv
`include "assert_macros.svh"

module sst_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  sst_pkg::cmd_type           cmd,
   output sst_pkg::status_type        status,
   input  sst_pkg::req_item_type      req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sst_pkg::rsp_item_type      rsp_item
);

   // slot table
   logic [sst_pkg::SLOTS-1:0] valid_ff;
   logic                      kind_ff   [sst_pkg::SLOTS];
   logic [2:0]                phase_ff  [sst_pkg::SLOTS];
   logic [31:0]               lip_ff    [sst_pkg::SLOTS];
   logic [15:0]               lport_ff  [sst_pkg::SLOTS];
   logic [31:0]               rip_ff    [sst_pkg::SLOTS];
   logic [15:0]               rport_ff  [sst_pkg::SLOTS];
   logic [7:0]                occ_ff, occ_in;

   // captured request
   sst_pkg::req_item_type     req_ff;

   // lookup stage results
   logic [sst_pkg::SLOT_W-1:0] hidx_ff, hidx_in;
   logic                       hit_ff, hit_in;
   logic [sst_pkg::SLOT_W-1:0] fidx_ff, fidx_in;
   logic                       free_ff, free_in;
   logic                       ekind_ff;
   logic [2:0]                 ephase_ff;
   logic [31:0]                elip_ff, erip_ff;
   logic [15:0]                elport_ff, erport_ff;

   // response register
   logic                       rsp_valid_ff;
   sst_pkg::rsp_item_type      rsp_ff, rsp_in;

   // execute-stage decisions
   logic                       ok;
   logic                       wr_open, wr_close, wr_bind, wr_conn, wr_phase;
   logic [2:0]                 new_phase;
   logic [sst_pkg::SLOT_W-1:0] widx;
   logic [7:0]                 hm1;
   logic                       tcp_ok, early_phase, pending_phase;

   // handle decode and lowest free slot
   always_comb begin
      hm1     = req_ff.handle - 8'd1;
      hidx_in = hm1[sst_pkg::SLOT_W-1:0];
      hit_in  = (req_ff.handle != 8'd0) && (req_ff.handle <= 8'(sst_pkg::SLOTS))
                && valid_ff[hidx_in];
      fidx_in = '0;
      free_in = 1'b0;
      for (int i = sst_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            fidx_in = sst_pkg::SLOT_W'(i);
            free_in = 1'b1;
         end
      end
   end

   // request capture and lookup registers
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.lookup) begin
         hidx_ff   <= hidx_in;
         hit_ff    <= hit_in;
         fidx_ff   <= fidx_in;
         free_ff   <= free_in;
         ekind_ff  <= kind_ff[hidx_in];
         ephase_ff <= phase_ff[hidx_in];
         elip_ff   <= lip_ff[hidx_in];
         elport_ff <= lport_ff[hidx_in];
         erip_ff   <= rip_ff[hidx_in];
         erport_ff <= rport_ff[hidx_in];
      end
   end

   // command rules
   always_comb begin
      tcp_ok        = hit_ff && (ekind_ff == sst_pkg::KIND_TCP);
      early_phase   = (ephase_ff == sst_pkg::PH_CREATED) || (ephase_ff == sst_pkg::PH_BOUND);
      pending_phase = (ephase_ff == sst_pkg::PH_CONNECTING)
                      || (ephase_ff == sst_pkg::PH_LISTENING);
      ok        = 1'b0;
      wr_open   = 1'b0;
      wr_close  = 1'b0;
      wr_bind   = 1'b0;
      wr_conn   = 1'b0;
      wr_phase  = 1'b0;
      new_phase = sst_pkg::PH_CREATED;
      case (req_ff.action)
         sst_pkg::ACT_OPEN: begin
            ok      = (req_ff.sock_type[1] == 1'b0) && free_ff;
            wr_open = ok;
         end
         sst_pkg::ACT_CLOSE: begin
            ok       = hit_ff;
            wr_close = ok;
         end
         sst_pkg::ACT_BIND: begin
            ok        = hit_ff && (ephase_ff == sst_pkg::PH_CREATED) && (req_ff.port != 16'd0);
            wr_bind   = ok;
            wr_phase  = ok;
            new_phase = sst_pkg::PH_BOUND;
         end
         sst_pkg::ACT_CONNECT: begin
            ok        = tcp_ok && early_phase && (req_ff.port != 16'd0);
            wr_conn   = ok;
            wr_phase  = ok;
            new_phase = sst_pkg::PH_CONNECTING;
         end
         sst_pkg::ACT_LISTEN: begin
            ok        = tcp_ok && early_phase && (elport_ff != 16'd0);
            wr_phase  = ok;
            new_phase = sst_pkg::PH_LISTENING;
         end
         sst_pkg::ACT_MARK: begin
            ok        = tcp_ok && pending_phase;
            wr_phase  = ok;
            new_phase = sst_pkg::PH_CONNECTED;
         end
         sst_pkg::ACT_GET: ok = hit_ff;
         default: ok = 1'b0;
      endcase
      widx = wr_open ? fidx_ff : hidx_ff;
   end

   // occupied count after this command
   always_comb begin
      occ_in = occ_ff;
      if (wr_open)  occ_in = occ_ff + 8'd1;
      if (wr_close) occ_in = occ_ff - 8'd1;
   end

   // response payload
   always_comb begin
      rsp_in            = '0;
      rsp_in.ok         = ok;
      rsp_in.open_count = occ_in;
      if (wr_open) rsp_in.new_handle = 8'(fidx_ff) + 8'd1;
      if (ok && (req_ff.action == sst_pkg::ACT_GET)) begin
         rsp_in.entry_kind      = ekind_ff;
         rsp_in.entry_phase     = ephase_ff;
         rsp_in.local_ip        = elip_ff;
         rsp_in.local_port_out  = elport_ff;
         rsp_in.remote_ip       = erip_ff;
         rsp_in.remote_port_out = erport_ff;
      end
   end

   // valid bits and count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= 8'd0;
      end else if (cmd.exec) begin
         occ_ff <= occ_in;
         if (wr_open)  valid_ff[widx] <= 1'b1;
         if (wr_close) valid_ff[widx] <= 1'b0;
      end
   end

   // slot field writes, one slot per command
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_open) begin
            kind_ff[widx]  <= req_ff.sock_type[0];
            phase_ff[widx] <= sst_pkg::PH_CREATED;
            lip_ff[widx]   <= 32'd0;
            lport_ff[widx] <= 16'd0;
            rip_ff[widx]   <= 32'd0;
            rport_ff[widx] <= 16'd0;
         end
         if (wr_phase) phase_ff[widx] <= new_phase;
         if (wr_bind) begin
            lip_ff[widx]   <= req_ff.address;
            lport_ff[widx] <= req_ff.port;
         end
         if (wr_conn) begin
            rip_ff[widx]   <= req_ff.address;
            rport_ff[widx] <= req_ff.port;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

   `SST_ASSERT(a_count_matches, occ_ff == 8'($countones(valid_ff)), "count differs from valid bits")
   `SST_ASSERT(a_no_overwrite, cmd.exec |-> !(rsp_valid_ff && !rsp_ready), "result overwritten")

endmodule

FILE: tb/socket_slot_table_tb.sv
`timescale 1ns / 1ps

module socket_slot_table_tb;

   // command code with no meaning to the block
   localparam logic [2:0] ACT_NONE = 3'd7;

   localparam int IDLE_MAX     = 12;
   localparam int RANDOM_ITEMS = 525;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // socket table tracker: mirrors the slot table and holds the replies still owed
   class socket_table_scoreboard;
      bit                    used [sst_pkg::SLOTS];
      logic                  kind_of [sst_pkg::SLOTS];
      sst_pkg::phase_type    phase_of [sst_pkg::SLOTS];
      logic [31:0]           local_addr [sst_pkg::SLOTS];
      logic [15:0]           bound_port [sst_pkg::SLOTS];
      logic [31:0]           peer_addr [sst_pkg::SLOTS];
      logic [15:0]           peer_port [sst_pkg::SLOTS];
      logic [7:0]            active;
      sst_pkg::rsp_item_type owed_replies [$];
      int                    errors;

      function new();
         active = '0;
         errors = 0;
         for (int i = 0; i < sst_pkg::SLOTS; i++) free_slot(i);
      endfunction

      function void free_slot(int i);
         used[i]       = 1'b0;
         kind_of[i]    = sst_pkg::KIND_TCP;
         phase_of[i]   = sst_pkg::PH_CREATED;
         local_addr[i] = '0;
         bound_port[i] = '0;
         peer_addr[i]  = '0;
         peer_port[i]  = '0;
      endfunction

      // random handle of an occupied slot, 0 when the table is empty
      function logic [7:0] live_handle();
         int picks [$];
         for (int i = 0; i < sst_pkg::SLOTS; i++) if (used[i]) picks.push_back(i);
         if (picks.size() == 0) return 8'd0;
         return 8'(picks[$urandom_range(0, picks.size() - 1)] + 1);
      endfunction

      // apply an accepted command to the mirror and queue the reply it owes
      function void note_request(sst_pkg::req_item_type r);
         sst_pkg::rsp_item_type e;
         bit                    hit;
         bit                    tcp;
         int                    s;
         e   = '0;
         hit = (r.handle != 8'd0) && (int'(r.handle) <= sst_pkg::SLOTS)
               && used[int'(r.handle) - 1];
         s   = hit ? int'(r.handle) - 1 : 0;
         tcp = hit && (kind_of[s] == sst_pkg::KIND_TCP);
         case (r.action)
            sst_pkg::ACT_OPEN: begin
               // lowest free slot wins, bad socket types are refused
               if (r.sock_type <= 2'd1) begin
                  for (int i = 0; i < sst_pkg::SLOTS && !e.ok; i++) begin
                     if (!used[i]) begin
                        free_slot(i);
                        used[i]      = 1'b1;
                        kind_of[i]   = r.sock_type[0];
                        active       = active + 8'd1;
                        e.ok         = 1'b1;
                        e.new_handle = 8'(i + 1);
                     end
                  end
               end
            end
            sst_pkg::ACT_CLOSE: begin
               if (hit) begin
                  free_slot(s);
                  active = active - 8'd1;
                  e.ok   = 1'b1;
               end
            end
            sst_pkg::ACT_BIND: begin
               if (hit && phase_of[s] == sst_pkg::PH_CREATED && r.port != 16'd0) begin
                  local_addr[s] = r.address;
                  bound_port[s] = r.port;
                  phase_of[s]   = sst_pkg::PH_BOUND;
                  e.ok          = 1'b1;
               end
            end
            sst_pkg::ACT_CONNECT: begin
               if (tcp && r.port != 16'd0 &&
                   (phase_of[s] == sst_pkg::PH_CREATED || phase_of[s] == sst_pkg::PH_BOUND)) begin
                  peer_addr[s] = r.address;
                  peer_port[s] = r.port;
                  phase_of[s]  = sst_pkg::PH_CONNECTING;
                  e.ok         = 1'b1;
               end
            end
            sst_pkg::ACT_LISTEN: begin
               if (tcp && bound_port[s] != 16'd0 &&
                   (phase_of[s] == sst_pkg::PH_CREATED || phase_of[s] == sst_pkg::PH_BOUND)) begin
                  phase_of[s] = sst_pkg::PH_LISTENING;
                  e.ok        = 1'b1;
               end
            end
            sst_pkg::ACT_MARK: begin
               if (tcp && (phase_of[s] == sst_pkg::PH_CONNECTING ||
                           phase_of[s] == sst_pkg::PH_LISTENING)) begin
                  phase_of[s] = sst_pkg::PH_CONNECTED;
                  e.ok        = 1'b1;
               end
            end
            sst_pkg::ACT_GET: begin
               if (hit) begin
                  e.ok              = 1'b1;
                  e.entry_kind      = kind_of[s];
                  e.entry_phase     = phase_of[s];
                  e.local_ip        = local_addr[s];
                  e.local_port_out  = bound_port[s];
                  e.remote_ip       = peer_addr[s];
                  e.remote_port_out = peer_port[s];
               end
            end
            default: ;
         endcase
         e.open_count = active;
         owed_replies.push_back(e);
      endfunction

      task report_mismatch(string what);
         $display("%0t: mismatch: %s", $time, what);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
      endtask

      // compare a reply beat with the oldest one owed
      task check_response(sst_pkg::rsp_item_type got);
         sst_pkg::rsp_item_type want;
         if (owed_replies.size() == 0) begin
            report_mismatch("reply beat while none is owed");
            return;
         end
         want = owed_replies.pop_front();
         compare_field("ok", got.ok, want.ok);
         compare_field("new_handle", got.new_handle, want.new_handle);
         compare_field("open_count", got.open_count, want.open_count);
         compare_field("entry_kind", got.entry_kind, want.entry_kind);
         compare_field("entry_phase", got.entry_phase, want.entry_phase);
         compare_field("local_ip", got.local_ip, want.local_ip);
         compare_field("local_port_out", got.local_port_out, want.local_port_out);
         compare_field("remote_ip", got.remote_ip, want.remote_ip);
         compare_field("remote_port_out", got.remote_port_out, want.remote_port_out);
      endtask
   endclass

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata  = '0;   // action, handle, sock_type, address, port
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;         // ok, new_handle, open_count, entry_kind, entry_phase,
                                    // local_ip, local_port_out, remote_ip, remote_port_out

   socket_table_scoreboard tracker = new();
   int sent_count     = 0;
   int received_count = 0;
   int cycle_count    = 0;

   socket_slot_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic sst_pkg::req_item_type make_req(logic [2:0] act, logic [7:0] h,
                                                      logic [1:0] st, logic [31:0] addr,
                                                      logic [15:0] p);
      sst_pkg::req_item_type r;
      r           = '0;
      r.action    = act;
      r.handle    = h;
      r.sock_type = st;
      r.address   = addr;
      r.port      = p;
      return r;
   endfunction

   // mostly live handles and legal types; open-heavy and close-heavy stretches alternate
   function automatic sst_pkg::req_item_type random_request(int n);
      sst_pkg::req_item_type r;
      int                    roll;
      int                    open_pct;
      int                    close_pct;
      r         = '0;
      open_pct  = ((n / 80) % 2 == 0) ? 40 : 12;
      close_pct = ((n / 80) % 2 == 0) ? 8 : 30;
      roll      = $urandom_range(0, 99);
      r.address = $urandom();
      r.port    = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom());
      r.sock_type = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(2, 3))
                                                : 2'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         r.handle = 8'($urandom_range(0, 255));
      end else begin
         r.handle = tracker.live_handle();
         if (r.handle == 8'd0) r.handle = 8'($urandom_range(1, sst_pkg::SLOTS));
      end
      if (roll < 2)
         r.action = ACT_NONE;
      else if (roll < 2 + open_pct)
         r.action = sst_pkg::ACT_OPEN;
      else if (roll < 2 + open_pct + close_pct)
         r.action = sst_pkg::ACT_CLOSE;
      else
         r.action = 3'($urandom_range(sst_pkg::ACT_BIND, sst_pkg::ACT_GET));
      return r;
   endfunction

   // present one command beat after a random gap, hold until taken
   task send_request(sst_pkg::req_item_type r);
      int gap;
      gap = ((sent_count / 50) % 4 == 3) ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(r);
      sent_count++;
   endtask

   // reply side: random stalls, with calm stretches
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = ((received_count / 70) % 4 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         tracker.check_response(sst_pkg::rsp_item_type'(rsp_tdata));
         received_count++;
      end
   end

   // reset, directed commands, random commands, drain
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table, both kinds, refused kinds
      send_request(make_req(sst_pkg::ACT_GET, 8'd1, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd1, 32'hffffffff, 16'hffff));
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd2, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd3, 32'h0, 16'h0));
      // tcp: listen needs a local port, bind needs a port and the created phase
      send_request(make_req(sst_pkg::ACT_LISTEN, 8'd1, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_BIND, 8'd1, 2'd0, 32'hffffffff, 16'h0));
      send_request(make_req(sst_pkg::ACT_BIND, 8'd1, 2'd0, 32'hffffffff, 16'hffff));
      send_request(make_req(sst_pkg::ACT_BIND, 8'd1, 2'd0, 32'h1, 16'h1));
      send_request(make_req(sst_pkg::ACT_LISTEN, 8'd1, 2'd3, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_CONNECT, 8'd1, 2'd0, 32'h1, 16'h1));
      send_request(make_req(sst_pkg::ACT_MARK, 8'd1, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_GET, 8'd1, 2'd0, 32'h0, 16'h0));
      // udp refuses connect and listen, but takes bind
      send_request(make_req(sst_pkg::ACT_CONNECT, 8'd2, 2'd0, 32'h5, 16'h5));
      send_request(make_req(sst_pkg::ACT_LISTEN, 8'd2, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_BIND, 8'd2, 2'd0, 32'h0, 16'h1));
      // tcp connect path
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_CONNECT, 8'd3, 2'd0, 32'hffffffff, 16'h0));
      send_request(make_req(sst_pkg::ACT_CONNECT, 8'd3, 2'd0, 32'hffffffff, 16'hffff));
      send_request(make_req(sst_pkg::ACT_MARK, 8'd3, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_MARK, 8'd3, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_GET, 8'd3, 2'd0, 32'h0, 16'h0));
      // bad handles and the unused command code
      send_request(make_req(sst_pkg::ACT_GET, 8'd0, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_GET, 8'(sst_pkg::SLOTS + 1), 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_CLOSE, 8'd255, 2'd0, 32'h0, 16'h0));
      send_request(make_req(ACT_NONE, 8'd1, 2'd0, 32'h0, 16'h0));
      // close, double close, slot reuse
      send_request(make_req(sst_pkg::ACT_CLOSE, 8'd1, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_CLOSE, 8'd1, 2'd0, 32'h0, 16'h0));
      send_request(make_req(sst_pkg::ACT_OPEN, 8'd0, 2'd0, 32'h0, 16'h0));

      for (int n = 0; n < RANDOM_ITEMS; n++) send_request(random_request(n));
      req_tvalid <= 1'b0;

      while (tracker.owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
